// ----- hdl/assert_macros.svh -----
// Assertion macros included by the page table unit core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ----- hdl/tlpt_pkg.sv -----
package tlpt_pkg;

    localparam int CMD_W      = 3;
    localparam int VP_W       = 20;
    localparam int FRAME_W    = 20;
    localparam int FLAGS_W    = 12;
    localparam int STATUS_W   = 3;
    localparam int IDX_FLD_W  = 10;
    localparam int ENTRY_W    = FRAME_W + FLAGS_W;

    localparam int DEF_DIR_ENTRIES   = 1024;
    localparam int DEF_TABLE_ENTRIES = 1024;
    localparam int DEF_TABLE_POOL    = 16;

    localparam int FLAG_PRESENT_BIT = 0;
    localparam int FLAG_USER_BIT    = 2;

    localparam logic [CMD_W-1:0] CMD_MAP        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TRANSLATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNMAP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR_USER = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_TABLES  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_MAPPED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_ACCESSIBLE = 3'd4;

endpackage

// ----- hdl/tlpt_cmd_if.sv -----
interface tlpt_cmd_if
    import tlpt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [VP_W-1:0]    virtual_page;
    logic [FRAME_W-1:0] frame;
    logic [FLAGS_W-1:0] perm_bits;

    modport source (output valid, command, virtual_page, frame, perm_bits, input ready);
    modport sink (input valid, command, virtual_page, frame, perm_bits, output ready);
endinterface

// ----- hdl/tlpt_rsp_if.sv -----
interface tlpt_rsp_if
    import tlpt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  result_frame;
    logic [FLAGS_W-1:0]  result_flags;

    modport source (output valid, status, result_frame, result_flags, input ready);
    modport sink (input valid, status, result_frame, result_flags, output ready);
endinterface

// ----- hdl/two_level_page_table_unit_core.sv -----
// Two-level page table unit.
// Commands arrive as beats on the cmd channel (command, virtual_page, frame,
// perm_bits) and each produces exactly one result beat on the rsp channel
// (status, result_frame, result_flags), in order.
// A command is walked through three synchronous memories: the directory, the
// reverse map from pool page to directory slot, and the table store. The result
// beat is registered after the directory read and the dependent table read,
// and a new command is accepted only after the walk of the last one is done.
// A map that needs a fresh table page first sweeps that page, one entry per
// cycle, before its result beat is registered.
// After reset the directory is written to zero, one slot per cycle, so no
// command is accepted until every slot is written. A slot only counts as
// valid when the pool page it names is handed out and that page points back
// at the slot, so clear-all only resets the pool count.
// The result register frees the walk from the receiver: a command may be
// accepted while a result beat waits. If the receiver stalls, the next
// command finishes its walk and then holds until the pending beat is taken.
`include "assert_macros.svh"

module two_level_page_table_unit_core
    import tlpt_pkg::*;
#(
    parameter int DIR_ENTRIES   = DEF_DIR_ENTRIES,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int TABLE_POOL    = DEF_TABLE_POOL
) (
    input  logic        clk,
    input  logic        rst_n,
    tlpt_cmd_if.sink    cmd,
    tlpt_rsp_if.source  rsp
);

    localparam int DI_W   = $clog2(DIR_ENTRIES);
    localparam int TI_W   = $clog2(TABLE_ENTRIES);
    localparam int PAGE_W = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int CNT_W  = $clog2(TABLE_POOL + 1);
    localparam int ADDR_W = $clog2(TABLE_POOL * TABLE_ENTRIES);

    localparam logic [IDX_FLD_W:0] DIR_LIM  = (IDX_FLD_W+1)'(DIR_ENTRIES);
    localparam logic [IDX_FLD_W:0] TBL_LIM  = (IDX_FLD_W+1)'(TABLE_ENTRIES);
    localparam logic [TI_W-1:0]    TE_LAST  = TI_W'(TABLE_ENTRIES - 1);
    localparam logic [DI_W-1:0]    DE_LAST  = DI_W'(DIR_ENTRIES - 1);
    localparam logic [CNT_W-1:0]   POOL_CNT = CNT_W'(TABLE_POOL);
    localparam logic [ADDR_W-1:0]  TE_A     = ADDR_W'(TABLE_ENTRIES);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIR   = 5'b00100,
        S_EVAL  = 5'b01000,
        S_CLEAR = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [VP_W-1:0]      vp_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [FLAGS_W-1:0]   perm_reg;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [TI_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [DI_W-1:0]      init_cnt_reg, init_cnt_next;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [FRAME_W-1:0]   rframe_reg, rframe_next;
    logic [FLAGS_W-1:0]   rflags_reg, rflags_next;
    logic                 load;
    logic                 rsp_free;

    logic                 dir_re, dir_we;
    logic [DI_W-1:0]      dir_waddr;
    logic [PAGE_W-1:0]    dir_wdata;
    logic [PAGE_W-1:0]    dir_rdata;
    logic                 own_re, own_we;
    logic [DI_W-1:0]      own_rdata;
    logic                 tbl_re, tbl_we;
    logic [ADDR_W-1:0]    tbl_raddr, tbl_waddr;
    logic [ENTRY_W-1:0]   tbl_wdata, tbl_rdata;

    logic [IDX_FLD_W-1:0] di_fld, ti_fld;
    logic [DI_W-1:0]      di_idx;
    logic [TI_W-1:0]      ti_idx;
    logic                 range_ok;
    logic                 hit;
    logic [FLAGS_W-1:0]   ent_flags;
    logic [FLAGS_W-1:0]   new_flags;
    logic [ENTRY_W-1:0]   new_entry;
    logic                 present;
    logic                 user;

    assign di_fld    = vp_reg[VP_W-1:IDX_FLD_W];
    assign ti_fld    = vp_reg[IDX_FLD_W-1:0];
    assign di_idx    = di_fld[DI_W-1:0];
    assign ti_idx    = ti_fld[TI_W-1:0];
    assign range_ok  = ({1'b0, di_fld} < DIR_LIM) && ({1'b0, ti_fld} < TBL_LIM);
    assign hit       = (CNT_W'(page_reg) < used_reg) && (own_rdata == di_idx);
    assign ent_flags = tbl_rdata[FLAGS_W-1:0];
    assign present   = ent_flags[FLAG_PRESENT_BIT];
    assign user      = ent_flags[FLAG_USER_BIT];
    assign new_flags = perm_reg | FLAGS_W'(1 << FLAG_PRESENT_BIT);
    assign new_entry = {frame_reg, new_flags};
    assign rsp_free  = !out_valid_reg || rsp.ready;

    assign tbl_raddr = ADDR_W'(dir_rdata) * TE_A + ADDR_W'(ti_idx);

    tlpt_ram #(.WIDTH(PAGE_W), .DEPTH(DIR_ENTRIES)) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (dir_re),
        .raddr (cmd.virtual_page[IDX_FLD_W +: DI_W]),
        .rdata (dir_rdata)
    );

    tlpt_ram #(.WIDTH(DI_W), .DEPTH(TABLE_POOL)) u_owner_ram (
        .clk   (clk),
        .we    (own_we),
        .waddr (page_reg),
        .wdata (di_idx),
        .re    (own_re),
        .raddr (dir_rdata),
        .rdata (own_rdata)
    );

    tlpt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_POOL * TABLE_ENTRIES)) u_table_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        page_next     = page_reg;
        used_next     = used_reg;
        clr_cnt_next  = clr_cnt_reg;
        init_cnt_next = init_cnt_reg;
        status_next   = ST_OK;
        rframe_next   = '0;
        rflags_next   = '0;
        load          = 1'b0;
        cmd.ready     = 1'b0;
        dir_re        = 1'b0;
        dir_we        = 1'b0;
        dir_waddr     = di_idx;
        dir_wdata     = page_reg;
        own_re        = 1'b0;
        own_we        = 1'b0;
        tbl_re        = 1'b0;
        tbl_we        = 1'b0;
        tbl_waddr     = ADDR_W'(page_reg) * TE_A + ADDR_W'(ti_idx);
        tbl_wdata     = '0;

        case (state_reg)
            S_INIT:
            begin
                dir_we    = 1'b1;
                dir_waddr = init_cnt_reg;
                dir_wdata = '0;
                if (init_cnt_reg != DE_LAST)
                begin
                    init_cnt_next = init_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                cmd.ready = 1'b1;
                dir_re    = cmd.valid;
                if (cmd.valid)
                begin
                    state_next = S_DIR;
                end
            end

            S_DIR:
            begin
                own_re     = 1'b1;
                tbl_re     = 1'b1;
                page_next  = dir_rdata;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                load = 1'b1;
                case (cmd_reg)
                    CMD_CLEAR_ALL:
                    begin
                        used_next = '0;
                    end
                    CMD_MAP, CMD_TRANSLATE, CMD_UNMAP, CMD_CLEAR_USER:
                    begin
                        if (!range_ok)
                        begin
                            status_next = ST_NO_TABLE;
                        end
                        else if (!hit)
                        begin
                            if (cmd_reg != CMD_MAP)
                            begin
                                status_next = ST_NO_TABLE;
                            end
                            else if (used_reg >= POOL_CNT)
                            begin
                                status_next = ST_OUT_OF_TABLES;
                            end
                            else
                            begin
                                load         = 1'b0;
                                page_next    = used_reg[PAGE_W-1:0];
                                clr_cnt_next = '0;
                                state_next   = S_CLEAR;
                            end
                        end
                        else
                        begin
                            rflags_next = ent_flags;
                            case (cmd_reg)
                                CMD_MAP:
                                begin
                                    if (present)
                                    begin
                                        status_next = ST_ALREADY_MAPPED;
                                    end
                                    else
                                    begin
                                        tbl_we      = rsp_free;
                                        tbl_wdata   = new_entry;
                                        rflags_next = new_flags;
                                    end
                                end
                                CMD_TRANSLATE:
                                begin
                                    if (present && user)
                                    begin
                                        rframe_next = tbl_rdata[ENTRY_W-1:FLAGS_W];
                                    end
                                    else
                                    begin
                                        status_next = ST_NOT_ACCESSIBLE;
                                    end
                                end
                                CMD_UNMAP:
                                begin
                                    if (present)
                                    begin
                                        tbl_we      = rsp_free;
                                        tbl_wdata   = '0;
                                        rframe_next = tbl_rdata[ENTRY_W-1:FLAGS_W];
                                    end
                                    else
                                    begin
                                        status_next = ST_NOT_ACCESSIBLE;
                                    end
                                end
                                default:
                                begin
                                    tbl_we    = rsp_free;
                                    tbl_wdata = tbl_rdata;
                                    tbl_wdata[FLAG_USER_BIT] = 1'b0;
                                    rflags_next = ent_flags;
                                    rflags_next[FLAG_USER_BIT] = 1'b0;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        status_next = ST_NOT_ACCESSIBLE;
                    end
                endcase

                if (load)
                begin
                    if (rsp_free)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        load      = 1'b0;
                        used_next = used_reg;
                    end
                end
            end

            S_CLEAR:
            begin
                tbl_we      = 1'b1;
                tbl_waddr   = ADDR_W'(page_reg) * TE_A + ADDR_W'(clr_cnt_reg);
                tbl_wdata   = (clr_cnt_reg == ti_idx) ? new_entry : '0;
                rflags_next = new_flags;
                if (clr_cnt_reg != TE_LAST)
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
                else if (rsp_free)
                begin
                    load       = 1'b1;
                    dir_we     = 1'b1;
                    own_we     = 1'b1;
                    used_next  = used_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            used_reg      <= '0;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            init_cnt_reg <= init_cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg    <= page_next;
        clr_cnt_reg <= clr_cnt_next;
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg   <= cmd.command;
            vp_reg    <= cmd.virtual_page;
            frame_reg <= cmd.frame;
            perm_reg  <= cmd.perm_bits;
        end
        if (load)
        begin
            status_reg <= status_next;
            rframe_reg <= rframe_next;
            rflags_reg <= rflags_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.result_frame = rframe_reg;
    assign rsp.result_flags = rflags_reg;

    `ASSERT_IMPLIES(a_clear_has_page, clk, rst_n, state_reg == S_CLEAR,
        used_reg < POOL_CNT, "page sweep started with the pool exhausted")
    `ASSERT_IMPLIES(a_used_step, clk, rst_n, used_reg != $past(used_reg),
        used_reg == '0 || used_reg == $past(used_reg) + 1'b1, "pool count jumped")
    `ASSERT_IMPLIES(a_dir_write_end, clk, rst_n, dir_we,
        state_reg == S_INIT || (state_reg == S_CLEAR && clr_cnt_reg == TE_LAST && rsp_free),
        "directory written outside the reset sweep or before the page sweep finished")

endmodule

// ----- hdl/tlpt_ram.sv -----
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
